// File: rtl/sli_pkg.sv
// Package for the sorted list block: sizes, codes and item types.
// Used by every module of the block; depends on nothing.
package sli_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int ENTRY_W = 5;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t [DEPTH-1:0] list_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_DELETED   = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		RD_IDLE,
		RD_SEND
	} rd_state_t;

	typedef struct packed {
		logic  mode;
		word_t key_value;
	} in_item_t;

	typedef struct packed {
		status_t              status;
		word_t                element;
		logic                 element_valid;
		logic [ENTRY_W-1:0]   entry_count;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		op_t   op;
		word_t key;
	} cmd_t;

	typedef struct packed {
		logic             go;
		status_t          status;
		logic [CNT_W-1:0] count;
	} exec_t;

endpackage

// File: rtl/sli_front.sv
// Front end: takes items, decodes the operation and queues the commands.
// Depends on sli_pkg.
module sli_front import sli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t cmd,
	output logic     cmd_valid,
	output cmd_t     cmd_out,
	input  logic     take
);

	cmd_t               q_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] fill_q;
	cmd_t               dec;
	logic               wr_en;
	logic               rd_en;

	always_comb begin
		dec.key = cmd.key_value;
		unique case (cmd.mode)
			1'b0:    dec.op = OP_INSERT;
			default: dec.op = OP_DELETE;
		endcase
	end

	assign full      = (fill_q == Q_CNT_W'(Q_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd_out   = q_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/sli_store.sv
// Back end store: a row of sorted cells that shift open to insert or closed to delete.
// Depends on sli_pkg.
module sli_store import sli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  cmd_t  cmd,
	output logic  take,
	input  logic  rd_idle,
	output exec_t exec,
	output list_t list
);

	list_t            store_q;
	logic [CNT_W-1:0] count_q;
	list_t            ins_list;
	list_t            del_list;
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] first;
	logic [DEPTH-1:0] hitv;
	logic             hit;
	logic             is_full;
	logic             ok;
	logic             go;

	// ge is monotone: stored values ascend and empty cells count as greater
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		assign ge[j]   = (CNT_W'(j) >= count_q) || ($signed(store_q[j]) >= $signed(cmd.key));
		assign hitv[j] = first[j] && (CNT_W'(j) < count_q) && (store_q[j] == cmd.key);
		if (j == 0) begin : g_head
			assign first[j]    = ge[j];
			assign ins_list[j] = ge[j] ? cmd.key : store_q[j];
		end else begin : g_body
			assign first[j]    = ge[j] && !ge[j-1];
			assign ins_list[j] = first[j] ? cmd.key : (ge[j] ? store_q[j-1] : store_q[j]);
		end
		if (j == DEPTH - 1) begin : g_tail
			assign del_list[j] = store_q[j];
		end else begin : g_mid
			assign del_list[j] = ge[j] ? store_q[j+1] : store_q[j];
		end
	end

	assign hit     = |hitv;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign go      = cmd_valid && rd_idle;
	assign take    = go;

	always_comb begin
		exec.go = go;
		unique case (cmd.op)
			OP_INSERT: begin
				ok          = !is_full;
				exec.status = is_full ? STAT_FULL : STAT_INSERTED;
				exec.count  = is_full ? count_q : count_q + 1'b1;
				list        = is_full ? store_q : ins_list;
			end
			default: begin
				ok          = hit;
				exec.status = hit ? STAT_DELETED : STAT_NOT_FOUND;
				exec.count  = hit ? count_q - 1'b1 : count_q;
				list        = hit ? del_list : store_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (go && ok) begin
			store_q <= list;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go) begin
			count_q <= exec.count;
		end
	end

endmodule

// File: rtl/sli_readout.sv
// Back end readout: snapshot of the list shifted out one result per item.
// Depends on sli_pkg.
module sli_readout import sli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  exec_t     exec,
	input  list_t     list,
	output logic      rd_idle,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	rd_state_t        state_q;
	rd_state_t        state_nxt;
	list_t            snap_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	status_t          status_q;
	logic             out_v_q;
	out_item_t        out_q;
	logic             emit;
	logic             final_one;

	assign final_one = (rem_q == CNT_W'(1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			RD_IDLE: if (exec.go) state_nxt = RD_SEND;
			RD_SEND: if (emit && final_one) state_nxt = RD_IDLE;
			default: state_nxt = RD_IDLE;
		endcase
	end

	always_comb begin
		rd_idle = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			RD_IDLE: rd_idle = 1'b1;
			RD_SEND: emit = !out_v_q || pop;
			default: rd_idle = 1'b0;
		endcase
	end

	assign empty  = !out_v_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (exec.go) begin
			snap_q   <= list;
			cnt_q    <= exec.count;
			status_q <= exec.status;
		end else if (emit) begin
			for (int j = 0; j < DEPTH - 1; j++) begin
				snap_q[j] <= snap_q[j+1];
			end
		end
		if (emit) begin
			out_q.status        <= status_q;
			out_q.element       <= (cnt_q == '0) ? '0 : snap_q[0];
			out_q.element_valid <= (cnt_q != '0);
			out_q.entry_count   <= ENTRY_W'(cnt_q);
			out_q.last          <= final_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
			rem_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec.go) begin
				rem_q <= (exec.count == '0) ? CNT_W'(1) : exec.count;
			end else if (emit) begin
				rem_q <= rem_q - 1'b1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/sorted_list_insert_delete.sv
// Top level of the sorted list block: front queue, cell store and readout.
// Depends on sli_pkg, sli_front, sli_store and sli_readout.
//
//   channel   handshake        payload      moves
//   command   push / full      cmd          one insert or delete item
//   result    empty / pop      result       one list element per item
//
// An operation updates the cell row, then the readout sends max(count, 1) results,
// one a cycle through the output register while pop keeps up with them.
// The two-entry command queue keeps taking items, until it is full, while the readout stalls on pop.
// Reset empties the list and both queues; no clearing pass is needed.
module sorted_list_insert_delete import sli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  cmd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic  cmd_valid;
	cmd_t  cmd_q;
	logic  take;
	logic  rd_idle;
	exec_t exec;
	list_t list;

	sli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_out   (cmd_q),
		.take      (take)
	);

	sli_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_q),
		.take      (take),
		.rd_idle   (rd_idle),
		.exec      (exec),
		.list      (list)
	);

	sli_readout u_readout (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec    (exec),
		.list    (list),
		.rd_idle (rd_idle),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: rtl/sli_checker.sv
// Port-level checks on the sorted list block, bound to its top level.
// Depends on sli_pkg and sorted_list_insert_delete.
module sli_checker import sli_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result item changed while waiting");

	a_empty_list: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.element_valid |-> result.last && result.entry_count == '0)
		else $error("empty list marker malformed");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == STAT_FULL |-> result.entry_count == ENTRY_W'(DEPTH))
		else $error("refused insert with list not full");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !result.last |=> !empty && result.element_valid
			&& result.status == $past(result.status)
			&& result.entry_count == $past(result.entry_count)
			&& $signed(result.element) >= $signed($past(result.element)))
		else $error("readout not contiguous or not ascending");

endmodule

bind sorted_list_insert_delete sli_checker u_chk (.*);
